// ===== src/assert_macros.svh =====
// assertion helper macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
    localparam int OPERAND_BITS_DEF = 31;
    localparam int WIDE_BITS = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] CMP_LESS    = 2'd0;
    localparam logic [1:0] CMP_EQUAL   = 2'd1;
    localparam logic [1:0] CMP_GREATER = 2'd2;

    // controller commands to the datapath
    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_LOAD   = 4'd1,  // capture request
        CMD_MUL1   = 4'd2,  // start-up products / gcd setup
        CMD_GSTEP  = 4'd3,  // start x % y
        CMD_GSWAP  = 4'd4,  // x <= y, y <= rem
        CMD_LCMDIV = 4'd5,  // start den-a / g
        CMD_LCMDV2 = 4'd6,  // start den-b / g
        CMD_LCMMUL = 4'd7,  // form l, m1, m2
        CMD_RSETUP = 4'd8,  // load gcd of result num/den
        CMD_RDIVN  = 4'd9,  // start num / g
        CMD_RDIVD  = 4'd10, // start den / g
        CMD_FINISH = 4'd11  // latch output
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic div_start;
    } ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic y_zero;
        logic is_addsub;
        logic is_muldiv;
        logic err_early;
        logic red_skip;
    } stat_t;
endpackage
`default_nettype wire

// ===== src/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rau_div #(
    parameter int W = rau_pkg::WIDE_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              busy,
    output logic [W-1:0]      quot,
    output logic [W-1:0]      rem
);
    localparam int CW = $clog2(W + 1);
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [W:0]    trial;

    always_comb begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        trial    = {r_reg, q_reg[W-1]};
        if (start) begin
            cnt_next = CW'(W);
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, d_reg}) begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule
`default_nettype wire

// ===== src/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, shared multipliers, gcd registers and shared divider
// ----------------------------------------------------------------------------
`default_nettype none
module rau_datapath #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rau_pkg::ctrl_t     ctrl,
    output rau_pkg::stat_t          stat,
    input  wire logic [2:0]         in_type,
    input  wire logic               in_a_neg,
    input  wire logic [30:0]        in_a_num,
    input  wire logic [30:0]        in_a_den,
    input  wire logic               in_b_neg,
    input  wire logic [30:0]        in_b_num,
    input  wire logic [30:0]        in_b_den,
    output logic                    out_neg,
    output logic [62:0]             out_num,
    output logic [62:0]             out_den,
    output logic [1:0]              out_cmp,
    output logic                    out_err
);
    localparam int W = rau_pkg::WIDE_BITS;
    localparam int OB = OPERAND_BITS;

    logic [2:0]    op_reg;
    logic          an_reg, bn_reg;
    logic [OB-1:0] am_reg, ad_reg, bm_reg, bd_reg;
    logic [W-1:0]  x_reg, y_reg, g_reg, n_reg, d_reg, m1_reg, m2_reg, t_reg;
    logic          neg_reg;
    logic [1:0]    cmp_reg;
    logic          res_neg_reg, res_err_reg;
    logic [62:0]   res_num_reg, res_den_reg;

    logic          div_busy;
    logic [W-1:0]  quot, rem, div_a, div_b;
    logic [W-1:0]  p1, p2;
    logic          is_addsub, bn_eff;

    assign is_addsub = (op_reg == rau_pkg::OP_ADD) || (op_reg == rau_pkg::OP_SUB);
    assign bn_eff    = bn_reg ^ (op_reg == rau_pkg::OP_SUB);

    // two narrow products share the start-up cycle; later stages reuse them
    always_comb begin
        p1 = '0;
        p2 = '0;
        case (ctrl.cmd)
            rau_pkg::CMD_MUL1: begin
                case (op_reg)
                    rau_pkg::OP_MUL: begin
                        p1 = W'(am_reg) * W'(bm_reg);
                        p2 = W'(ad_reg) * W'(bd_reg);
                    end
                    default: begin
                        p1 = W'(am_reg) * W'(bd_reg);
                        p2 = W'(ad_reg) * W'(bm_reg);
                    end
                endcase
            end
            rau_pkg::CMD_LCMMUL: begin
                // t = ad/g, quot = bd/g
                p1 = W'(am_reg) * W'(quot[OB-1:0]);
                p2 = W'(bm_reg) * W'(t_reg[OB-1:0]);
            end
            default: begin
                p1 = '0;
                p2 = '0;
            end
        endcase
    end

    always_comb begin
        div_a = x_reg;
        div_b = y_reg;
        case (ctrl.cmd)
            rau_pkg::CMD_LCMDIV: begin
                div_a = W'(ad_reg);
                div_b = x_reg;
            end
            rau_pkg::CMD_LCMDV2: begin
                div_a = W'(bd_reg);
                div_b = g_reg;
            end
            rau_pkg::CMD_RDIVN: begin
                div_a = n_reg;
                div_b = x_reg;
            end
            rau_pkg::CMD_RDIVD: begin
                div_a = d_reg;
                div_b = g_reg;
            end
            default: begin
                div_a = x_reg;
                div_b = y_reg;
            end
        endcase
    end

    rau_div #(.W(W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quot     (quot),
        .rem      (rem)
    );

    logic [W-1:0] sum_mag;
    logic         sum_neg;
    always_comb begin
        if (an_reg == bn_eff) begin
            sum_mag = m1_reg + m2_reg;
            sum_neg = an_reg;
        end else if (m1_reg >= m2_reg) begin
            sum_mag = m1_reg - m2_reg;
            sum_neg = an_reg;
        end else begin
            sum_mag = m2_reg - m1_reg;
            sum_neg = bn_eff;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.cmd)
            rau_pkg::CMD_LOAD: begin
                op_reg <= in_type;
                an_reg <= in_a_neg;
                bn_reg <= in_b_neg;
                am_reg <= in_a_num[OB-1:0];
                ad_reg <= in_a_den[OB-1:0];
                bm_reg <= in_b_num[OB-1:0];
                bd_reg <= in_b_den[OB-1:0];
            end
            rau_pkg::CMD_MUL1: begin
                n_reg   <= p1;
                d_reg   <= p2;
                neg_reg <= an_reg ^ bn_reg;
                // gcd of denominators for add/sub
                x_reg   <= W'(ad_reg);
                y_reg   <= W'(bd_reg);
                cmp_reg <= rau_pkg::CMP_LESS;
                if (op_reg == rau_pkg::OP_CMP) begin
                    logic xneg, yneg;
                    xneg = an_reg && (p1 != '0);
                    yneg = bn_reg && (p2 != '0);
                    if (xneg != yneg)
                        cmp_reg <= xneg ? rau_pkg::CMP_LESS : rau_pkg::CMP_GREATER;
                    else if (p1 == p2)
                        cmp_reg <= rau_pkg::CMP_EQUAL;
                    else if (xneg)
                        cmp_reg <= (p1 > p2) ? rau_pkg::CMP_LESS : rau_pkg::CMP_GREATER;
                    else
                        cmp_reg <= (p1 < p2) ? rau_pkg::CMP_LESS : rau_pkg::CMP_GREATER;
                end
            end
            rau_pkg::CMD_GSWAP: begin
                x_reg <= y_reg;
                y_reg <= rem;
            end
            rau_pkg::CMD_LCMDIV: begin
                g_reg <= x_reg;
            end
            rau_pkg::CMD_LCMDV2: begin
                t_reg <= quot;
            end
            rau_pkg::CMD_LCMMUL: begin
                // l = (ad/g)*bd, sum of m1, m2 formed next cycle via regs
                d_reg  <= W'(t_reg[OB-1:0]) * W'(bd_reg);
                m1_reg <= p1;
                m2_reg <= p2;
            end
            rau_pkg::CMD_RSETUP: begin
                if (is_addsub) begin
                    n_reg   <= sum_mag;
                    neg_reg <= sum_neg;
                    x_reg   <= sum_mag;
                end else begin
                    x_reg   <= n_reg;
                end
                y_reg <= d_reg;
            end
            rau_pkg::CMD_RDIVN: begin
                g_reg <= x_reg;
            end
            rau_pkg::CMD_RDIVD: begin
                n_reg <= quot;
            end
            default: begin
            end
        endcase
    end

    // output register written at finish
    always_ff @(posedge aclk) begin
        if (ctrl.cmd == rau_pkg::CMD_FINISH) begin
            res_neg_reg <= 1'b0;
            res_num_reg <= '0;
            res_den_reg <= 63'd1;
            res_err_reg <= 1'b0;
            if (is_addsub) begin
                if (ad_reg == '0 || bd_reg == '0) begin
                    res_num_reg <= 63'd1;
                    res_err_reg <= 1'b1;
                end else begin
                    res_neg_reg <= neg_reg;
                    res_num_reg <= n_reg[62:0];
                    res_den_reg <= stat.red_skip ? d_reg[62:0] : quot[62:0];
                end
            end else if (op_reg == rau_pkg::OP_MUL || op_reg == rau_pkg::OP_DIV) begin
                res_neg_reg <= neg_reg;
                if (d_reg == '0) begin
                    res_num_reg <= 63'd1;
                    res_err_reg <= 1'b1;
                end else begin
                    res_num_reg <= n_reg[62:0];
                    res_den_reg <= stat.red_skip ? d_reg[62:0] : quot[62:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cmd == rau_pkg::CMD_FINISH) begin
            out_cmp <= cmp_reg;
        end
    end

    assign stat.div_busy  = div_busy;
    assign stat.y_zero    = (y_reg == '0);
    assign stat.is_addsub = is_addsub;
    assign stat.is_muldiv = (op_reg == rau_pkg::OP_MUL) || (op_reg == rau_pkg::OP_DIV);
    assign stat.err_early = (ad_reg == '0) || (bd_reg == '0);
    // zero numerator or zero denominator: no reduction
    assign stat.red_skip  = (n_reg == '0) || (d_reg == '0);

    assign out_neg = res_neg_reg;
    assign out_num = res_num_reg;
    assign out_den = res_den_reg;
    assign out_err = res_err_reg;
endmodule
`default_nettype wire

// ===== src/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: gcd loops and divider steps of one request, output handshake
// ----------------------------------------------------------------------------
`default_nettype none
module rau_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rau_pkg::ctrl_t      ctrl,
    input  wire rau_pkg::stat_t stat
);
    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_MUL    = 12'b000000000010,
        S_GCHK   = 12'b000000000100,
        S_GWAIT  = 12'b000000001000,
        S_LDIV   = 12'b000000010000,
        S_LDIV2  = 12'b000000100000,
        S_LMUL   = 12'b000001000000,
        S_RSET   = 12'b000010000000,
        S_RDIVN  = 12'b000100000000,
        S_RDIVD  = 12'b001000000000,
        S_FIN    = 12'b010000000000,
        S_WAITD  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   red_phase_reg, red_phase_next;  // gcd loop belongs to reduction

    always_comb begin
        state_next     = state_reg;
        ov_next        = ov_reg;
        red_phase_next = red_phase_reg;
        ctrl.cmd       = rau_pkg::CMD_NONE;
        ctrl.div_start = 1'b0;
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    ctrl.cmd   = rau_pkg::CMD_LOAD;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                ctrl.cmd       = rau_pkg::CMD_MUL1;
                red_phase_next = 1'b0;
                if (stat.is_addsub && !stat.err_early) state_next = S_GCHK;
                else if (stat.is_muldiv) state_next = S_RSET;
                else state_next = S_FIN;
            end
            S_GCHK: begin
                if (stat.y_zero) begin
                    state_next = red_phase_reg ? S_RDIVN : S_LDIV;
                end else begin
                    ctrl.cmd       = rau_pkg::CMD_GSTEP;
                    ctrl.div_start = 1'b1;
                    state_next     = S_GWAIT;
                end
            end
            S_GWAIT: begin
                if (!stat.div_busy) begin
                    ctrl.cmd   = rau_pkg::CMD_GSWAP;
                    state_next = S_GCHK;
                end
            end
            S_LDIV: begin
                ctrl.cmd       = rau_pkg::CMD_LCMDIV;
                ctrl.div_start = 1'b1;
                state_next     = S_LDIV2;
            end
            S_LDIV2: begin
                if (!stat.div_busy) begin
                    ctrl.cmd       = rau_pkg::CMD_LCMDV2;
                    ctrl.div_start = 1'b1;
                    state_next     = S_LMUL;
                end
            end
            S_LMUL: begin
                if (!stat.div_busy) begin
                    ctrl.cmd   = rau_pkg::CMD_LCMMUL;
                    state_next = S_RSET;
                end
            end
            S_RSET: begin
                ctrl.cmd       = rau_pkg::CMD_RSETUP;
                red_phase_next = 1'b1;
                state_next     = S_WAITD;
            end
            S_WAITD: begin
                // n and d now final; skip reduction for zero num or den
                state_next = stat.red_skip ? S_FIN : S_GCHK;
            end
            S_RDIVN: begin
                ctrl.cmd       = rau_pkg::CMD_RDIVN;
                ctrl.div_start = 1'b1;
                state_next     = S_RDIVD;
            end
            S_RDIVD: begin
                if (!stat.div_busy) begin
                    ctrl.cmd       = rau_pkg::CMD_RDIVD;
                    ctrl.div_start = 1'b1;
                    state_next     = S_FIN;
                end
            end
            S_FIN: begin
                if (!stat.div_busy && !ov_reg) begin
                    ctrl.cmd   = rau_pkg::CMD_FINISH;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ov_reg        <= 1'b0;
            red_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ov_reg        <= ov_next;
            red_phase_reg <= red_phase_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// ===== src/rational_arithmetic_unit_top.sv =====
// compare, unused codes and add/sub with a zero denominator finish after the start-up
// products; a multiply or divide with a zero numerator or zero denominator skips reduction;
// otherwise each gcd step and each quotient runs on the shared radix-2 divider
// throughput: one request at a time; the next is taken while the last result still waits
// reset: synchronous active-low aresetn clears the sequencer and the output valid
`default_nettype none
module rational_arithmetic_unit_top #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // req_type[2:0], a_neg[3], a_num[34:4], a_den[65:35], b_neg[66], b_num[97:67],
    // b_den[128:98], zero pad to 136
    input  wire logic [135:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // res_neg[0], res_num[63:1], res_den[126:64], cmp_result[128:127],
    // zero_den_error[129], zero pad to 136
    output logic [135:0]       m_tdata
);
    rau_pkg::ctrl_t ctrl;
    rau_pkg::stat_t stat;
    logic        o_neg, o_err;
    logic [62:0] o_num, o_den;
    logic [1:0]  o_cmp;

    rau_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stat     (stat),
        .in_type  (s_tdata[2:0]),
        .in_a_neg (s_tdata[3]),
        .in_a_num (s_tdata[34:4]),
        .in_a_den (s_tdata[65:35]),
        .in_b_neg (s_tdata[66]),
        .in_b_num (s_tdata[97:67]),
        .in_b_den (s_tdata[128:98]),
        .out_neg  (o_neg),
        .out_num  (o_num),
        .out_den  (o_den),
        .out_cmp  (o_cmp),
        .out_err  (o_err)
    );

    assign m_tdata = {6'd0, o_err, o_cmp, o_den, o_num, o_neg};
endmodule
`default_nettype wire

// ===== src/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks of the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rau_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata
);
    `ASSERT_NEXT(a_one_req, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request overlap")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `ASSERT_IMPL(a_den_nz, aclk, aresetn, m_tvalid, m_tdata[126:64] != 63'd0, "zero denominator out")
    `ASSERT_IMPL(a_cmp_ok, aclk, aresetn, m_tvalid, m_tdata[128:127] != 2'd3, "bad compare code")
endmodule
bind rational_arithmetic_unit_top rau_checker u_rau_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the rational arithmetic unit: directed corner requests,
// random fractions across all operations, random gaps and a long output stall;
// every result is checked against a behavioral predictor in request order
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    localparam int N_RANDOM = 730;
    localparam int STALL_LIMIT = 200000;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    typedef struct packed {
        logic        err;
        logic [1:0]  cmp;
        logic [62:0] den;
        logic [62:0] num;
        logic        neg;
    } rat_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [135:0] m_tdata;

    rat_result_t expected_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_sink = 1'b0;
    int sink_hold_len = 0;

    rational_arithmetic_unit_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        if (x == 0 || y == 0) return 64'd1;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic rat_result_t reduced(logic neg, logic [63:0] num, logic [63:0] den);
        rat_result_t r;
        logic [63:0] g;
        r = '0;
        if (den == 0) begin
            r.neg = neg; r.num = 63'd1; r.den = 63'd1; r.err = 1'b1;
            return r;
        end
        if (num != 0) begin
            g = gcd64(num, den);
            num = num / g;
            den = den / g;
        end
        r.neg = neg; r.num = num[62:0]; r.den = den[62:0];
        return r;
    endfunction

    function automatic rat_result_t fraction_result(logic [135:0] d);
        logic [2:0] op;
        logic an, bn;
        logic [63:0] am, ad, bm, bd, g, l, m1, m2, mag, x, y;
        logic neg, xneg, yneg;
        rat_result_t r;
        op = d[2:0]; an = d[3]; am = 64'(d[34:4]); ad = 64'(d[65:35]);
        bn = d[66]; bm = 64'(d[97:67]); bd = 64'(d[128:98]);
        r = '0;
        r.den = 63'd1;
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                if (op == rau_pkg::OP_SUB) bn = ~bn;
                if (ad == 0 || bd == 0) begin
                    r.num = 63'd1; r.err = 1'b1;
                    return r;
                end
                g = gcd64(ad, bd);
                l = (ad / g) * bd;
                m1 = am * (bd / g);
                m2 = bm * (ad / g);
                if (an == bn) begin
                    mag = m1 + m2; neg = an;
                end else if (m1 >= m2) begin
                    mag = m1 - m2; neg = an;
                end else begin
                    mag = m2 - m1; neg = bn;
                end
                if (mag == 0) neg = 1'b0;
                return reduced(neg, mag, l);
            end
            rau_pkg::OP_MUL: return reduced(an ^ bn, am * bm, ad * bd);
            rau_pkg::OP_DIV: return reduced(an ^ bn, am * bd, ad * bm);
            rau_pkg::OP_CMP: begin
                x = am * bd;
                y = bm * ad;
                xneg = an && x != 0;
                yneg = bn && y != 0;
                if (xneg != yneg) r.cmp = xneg ? rau_pkg::CMP_LESS : rau_pkg::CMP_GREATER;
                else if (x == y) r.cmp = rau_pkg::CMP_EQUAL;
                else if (xneg) r.cmp = (x > y) ? rau_pkg::CMP_LESS : rau_pkg::CMP_GREATER;
                else r.cmp = (x < y) ? rau_pkg::CMP_LESS : rau_pkg::CMP_GREATER;
                return r;
            end
            default: return r;
        endcase
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rat_result_t got, want;
            got = m_tdata[129:0];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.neg !== want.neg) begin
                    $display("%0t: res_neg expected %0d actual %0d", $time, want.neg, got.neg);
                    errors++;
                end
                if (got.num !== want.num) begin
                    $display("%0t: res_num expected %0d actual %0d", $time, want.num, got.num);
                    errors++;
                end
                if (got.den !== want.den) begin
                    $display("%0t: res_den expected %0d actual %0d", $time, want.den, got.den);
                    errors++;
                end
                if (got.cmp !== want.cmp) begin
                    $display("%0t: cmp_result expected %0d actual %0d", $time, want.cmp, got.cmp);
                    errors++;
                end
                if (got.err !== want.err) begin
                    $display("%0t: zero_den_error expected %0d actual %0d", $time,
                             want.err, got.err);
                    errors++;
                end
            end
        end
    end

    // sink: random stalls, plus a long counted hold when requested
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                for (int i = 0; i < sink_hold_len; i++) @(posedge aclk);
                hold_sink = 1'b0;
            end
            n = gap_len();
            if (n > 0) begin
                m_tready <= 1'b0;
                for (int i = 1; i < n; i++) @(posedge aclk);
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            for (int i = $urandom_range(0, 20); i > 0; i--) @(posedge aclk);
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL rational_arithmetic_unit_top");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] op, logic an, logic [30:0] am, logic [30:0] ad,
                                logic bn, logic [30:0] bm, logic [30:0] bd, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        for (int i = 0; i < n; i++) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {7'd0, bd, bm, bn, ad, am, an, op};
        s_tvalid <= 1'b1;
        expected_q.push_back(fraction_result({7'd0, bd, bm, bn, ad, am, an, op}));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [30:0] rand_field(bit allow_zero);
        logic [30:0] v;
        case ($urandom_range(0, 5))
            0: v = 31'($urandom_range(0, 15));
            1: v = 31'($urandom_range(0, 1000));
            2: v = MAX31 - 31'($urandom_range(0, 20));
            default: v = 31'($urandom);
        endcase
        if (!allow_zero && v == 0) v = 31'd1;
        return v;
    endfunction

    task automatic test_directed();
        send_request(rau_pkg::OP_ADD, 0, 1, 2, 0, 1, 3, 0);
        send_request(rau_pkg::OP_ADD, 0, 5, 7, 1, 5, 7, 0);           // sum is zero
        send_request(rau_pkg::OP_ADD, 1, MAX31, MAX31, 1, MAX31, 1, 0);
        send_request(rau_pkg::OP_SUB, 0, 3, 4, 0, 3, 4, 0);
        send_request(rau_pkg::OP_SUB, 1, MAX31, 1, 0, MAX31, 1, 0);
        send_request(rau_pkg::OP_SUB, 0, 1, MAX31, 1, 1, MAX31 - 31'd1, 0);
        send_request(rau_pkg::OP_MUL, 1, MAX31, 1, 0, MAX31, 1, 0);
        send_request(rau_pkg::OP_MUL, 0, 0, 9, 1, 4, 6, 0);           // zero product
        send_request(rau_pkg::OP_MUL, 1, 6, 35, 1, 14, 9, 0);
        send_request(rau_pkg::OP_DIV, 0, 3, 5, 1, 0, 7, 0);           // divide by zero
        send_request(rau_pkg::OP_DIV, 1, 0, 5, 0, 2, 7, 0);
        send_request(rau_pkg::OP_DIV, 0, MAX31, 1, 0, 1, MAX31, 0);
        send_request(rau_pkg::OP_ADD, 0, 1, 0, 0, 1, 3, 0);           // zero operand denominators
        send_request(rau_pkg::OP_SUB, 1, 1, 3, 0, 1, 0, 0);
        send_request(rau_pkg::OP_MUL, 0, 1, 0, 0, 1, 3, 0);
        send_request(rau_pkg::OP_CMP, 1, 0, 3, 0, 0, 5, 0);           // negative zero equals zero
        send_request(rau_pkg::OP_CMP, 0, 1, 2, 0, 2, 4, 0);
        send_request(rau_pkg::OP_CMP, 1, 1, 2, 0, 1, 3, 0);
        send_request(rau_pkg::OP_CMP, 1, 1, 2, 1, 1, 3, 0);
        send_request(rau_pkg::OP_CMP, 0, MAX31, 1, 0, MAX31, 2, 0);
        send_request(rau_pkg::OP_CMP, 0, 1, 0, 0, 1, 0, 0);
        send_request(3'd5, 1, MAX31, MAX31, 1, MAX31, MAX31, 0);
        send_request(3'd7, 0, 0, 0, 0, 0, 0, 0);
        drop_valid();
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_request(op, 1'($urandom), rand_field(1), rand_field($urandom_range(0, 40) == 0),
                         1'($urandom), rand_field(1), rand_field($urandom_range(0, 40) == 0), 1);
        end
        drop_valid();
    endtask

    task automatic test_output_stall();
        sink_hold_len = 3000;
        hold_sink = 1'b1;
        for (int i = 0; i < 6; i++)
            send_request(rau_pkg::OP_CMP, 1'($urandom), rand_field(1), rand_field(0),
                         1'($urandom), rand_field(1), rand_field(0), 0);
        drop_valid();
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_output_stall();
        test_random(N_RANDOM);
        wait_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASS rational_arithmetic_unit_top");
        end else begin
            $display("FAIL rational_arithmetic_unit_top");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+src
src/rau_pkg.sv
src/rau_div.sv
src/rau_datapath.sv
src/rau_ctrl.sv
src/rational_arithmetic_unit_top.sv
src/rau_checker.sv
sim/tb_top.sv
